// ===== rtl/cbst_pkg.sv =====
package cbst_pkg;

  // payload widths
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned WIDTH_W     = 31;
  localparam int unsigned SEG_W       = 6;
  localparam int unsigned VNUM_W      = 16;
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned IN_TDATA_W  = 296;
  localparam int unsigned OUT_TDATA_W = 192;

  // datapath widths
  localparam int unsigned DIFF_W = 33;  // control polygon edge
  localparam int unsigned MUL_W  = 33;  // shared multiplier operand
  localparam int unsigned PROD_W = 66;
  localparam int unsigned ACC_W  = 53;  // weighted point sum
  localparam int unsigned TAN_W  = 48;  // tangent components
  localparam int unsigned DVD_W  = 62;  // dividend
  localparam int unsigned DVS_W  = 32;  // divisor
  localparam int unsigned QUO_W  = 33;  // used quotient bits
  localparam int unsigned SQV_W  = 62;  // radicand
  localparam int unsigned LEN_W  = 31;  // tangent length
  localparam int unsigned COEF_W = 18;  // cubic weights
  localparam int unsigned SQR_W  = 12;  // quadratic weights

  // item kind
  localparam logic KIND_CLEAR = 1'b1;

  // tangent normalisation window [2^29, 2^30)
  localparam logic [TAN_W-1:0] NORM_HI = 48'h0000_4000_0000;
  localparam logic [TAN_W-1:0] NORM_LO = 48'h0000_2000_0000;

  typedef struct packed {
    logic                      is_clear;
    logic [SEG_W-1:0]          segs;
    logic [WIDTH_W-1:0]        width;
    logic signed [COORD_W-1:0] p0x;
    logic signed [COORD_W-1:0] p0y;
    logic signed [COORD_W-1:0] p3x;
    logic signed [COORD_W-1:0] p3y;
    logic signed [COORD_W-1:0] c1x;
    logic signed [COORD_W-1:0] c1y;
    logic signed [COORD_W-1:0] c2x;
    logic signed [COORD_W-1:0] c2y;
  } cmd_t;

  typedef struct packed {
    logic [COLOR_W-1:0]        color;
    logic [VNUM_W-1:0]         right_num;
    logic [VNUM_W-1:0]         left_num;
    logic signed [COORD_W-1:0] right_y;
    logic signed [COORD_W-1:0] right_x;
    logic signed [COORD_W-1:0] left_y;
    logic signed [COORD_W-1:0] left_x;
    logic                      closes_quad;
    logic                      last;
  } vtx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_COEF1, ST_COEF2, ST_MUL, ST_ACC, ST_DIV_GO, ST_DIV_WAIT,
    ST_NORM, ST_SQ1, ST_SQ2, ST_SQ3, ST_SQRT, ST_OFS_MUL, ST_EMIT
  } seq_state_e;

  typedef enum logic [1:0] {
    DIV_PX, DIV_PY, DIV_OX, DIV_OY
  } div_sel_e;

endpackage

// ===== rtl/cubic_bezier_stroke_tessellator.sv =====
// Cubic Bezier stroke tessellator. A draw item (tuser 0) carries a curve and a
// stroke width and yields segments+1 vertex pairs, one result item per pair,
// with tlast on the final pair; segments of zero yields nothing, and a clear
// item (tuser 1) restarts vertex numbering at zero. Items are worked one at a
// time by a single sequencer behind a two item input queue, so a new item is
// taken while the previous curve is still in progress. The work for each pair
// is dominated by four divisions on the shared bit-serial divider, plus the
// normalising steps, squaring and the square root, the 14 multiply-accumulate
// steps on the one shared multiplier, and set-up and emit. A pair whose
// tangent vanishes skips the offset work; output stalls hold the sequencer.
module cubic_bezier_stroke_tessellator #(
  parameter int unsigned MAX_SEGMENTS = 63
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // start_x, start_y, end_x, end_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y,
  // stroke_width, segments, zero fill
  input  logic [cbst_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // kind
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // left_x, left_y, right_x, right_y, left_number, right_number, pixel_color
  output logic [cbst_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // closes_quad
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we_i,
  input  logic [cbst_pkg::COLOR_W-1:0]      cfg_wdata_i
);
  import cbst_pkg::*;

  logic [COLOR_W-1:0] color_q;
  logic               cmd_valid, cmd_ready;
  cmd_t               cmd;
  vtx_t               vtx;

  // vertex colour register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= '1;
    end else if (cfg_we_i) begin
      color_q <= cfg_wdata_i;
    end
  end

  cbst_front #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_kind_i(s_axis_tuser), .in_data_i(s_axis_tdata),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  cbst_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .color_i(color_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_o(vtx)
  );

  // result item packing
  assign m_axis_tdata = {vtx.color, vtx.right_num, vtx.left_num,
                         vtx.right_y, vtx.right_x, vtx.left_y, vtx.left_x};
  assign m_axis_tuser = vtx.closes_quad;
  assign m_axis_tlast = vtx.last;

endmodule

// ===== rtl/cbst_front.sv =====
module cbst_front #(
  parameter int unsigned MAX_SEGMENTS = 63
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           in_kind_i,
  input  logic [cbst_pkg::IN_TDATA_W-1:0] in_data_i,
  output logic                           cmd_valid_o,
  input  logic                           cmd_ready_i,
  output cbst_pkg::cmd_t                 cmd_o
);
  import cbst_pkg::*;

  cmd_t       q_mem [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       dec;
  logic [SEG_W-1:0] seg_raw;

  // classify and unpack the incoming item
  always_comb begin
    seg_raw      = in_data_i[292:287];
    dec.is_clear = (in_kind_i == KIND_CLEAR);
    dec.segs     = (seg_raw > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : seg_raw;
    dec.width    = in_data_i[286:256];
    dec.p0x      = in_data_i[31:0];
    dec.p0y      = in_data_i[63:32];
    dec.p3x      = in_data_i[95:64];
    dec.p3y      = in_data_i[127:96];
    dec.c1x      = in_data_i[159:128];
    dec.c1y      = in_data_i[191:160];
    dec.c2x      = in_data_i[223:192];
    dec.c2y      = in_data_i[255:224];
  end

  // two entry queue towards the sequencer
  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= dec;
    end
  end

endmodule

// ===== rtl/cbst_div.sv =====
module cbst_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cbst_pkg::DVD_W-1:0] num_i,
  input  logic [cbst_pkg::DVS_W-1:0] den_i,
  output logic                      done_o,
  output logic [cbst_pkg::QUO_W-1:0] quot_o
);
  import cbst_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W:0]   rem_q, rem_sh;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] den_q;
  logic             ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
    ge     = (rem_sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q[QUO_W-1:0];

endmodule

// ===== rtl/cbst_sqrt.sv =====
module cbst_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cbst_pkg::SQV_W-1:0] val_i,
  output logic                      done_o,
  output logic [cbst_pkg::LEN_W-1:0] root_o
);
  import cbst_pkg::*;

  logic             busy_q, done_q;
  logic [SQV_W-1:0] v_q, r_q, bit_q;
  logic [SQV_W:0]   trial;
  logic             fits;

  // digit by digit integer square root, two radicand bits per cycle
  always_comb begin
    trial = {1'b0, r_q} + {1'b0, bit_q};
    fits  = ({1'b0, v_q} >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (bit_q == SQV_W'(1))) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      r_q   <= '0;
      bit_q <= SQV_W'(1) << (SQV_W - 2);
    end else if (busy_q) begin
      if (fits) begin
        v_q <= v_q - trial[SQV_W-1:0];
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[LEN_W-1:0];

endmodule

// ===== rtl/cbst_back.sv =====
module cbst_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  cbst_pkg::cmd_t              cmd_i,
  input  logic [cbst_pkg::COLOR_W-1:0] color_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output cbst_pkg::vtx_t              out_o
);
  import cbst_pkg::*;

  // last term of each weighted sum
  localparam logic [3:0] K_PX_END = 4'd3;
  localparam logic [3:0] K_PY_END = 4'd7;
  localparam logic [3:0] K_TX_END = 4'd10;
  localparam logic [3:0] K_TY_END = 4'd13;

  seq_state_e state_q, state_d;
  div_sel_e   sel_q, sel_d;
  logic [3:0] k_q, k_d;
  logic [SEG_W-1:0] i_q, i_d, n_q, n_d, u_w;
  logic [VNUM_W-1:0] vcnt_q, vcnt_d;
  logic out_valid_q, out_valid_d;
  vtx_t out_q, out_d;

  // curve and step payload
  logic [WIDTH_W-1:0] w_q;
  logic signed [COORD_W-1:0] p0x_q, p0y_q, p3x_q, p3y_q, c1x_q, c1y_q, c2x_q, c2y_q;
  logic signed [DIFF_W-1:0] d0x_q, d0y_q, d1x_q, d1y_q, d2x_q, d2y_q;
  logic [SQR_W-1:0] uu_q, tt_q, ut_q, nn_q, ce_q, cg_q;
  logic [SQR_W:0] cf_q;
  logic [COEF_W-1:0] ca_q, cb_q, cc_q, cd_q, n3_q;
  logic [19:0] cb_w, cc_w;
  logic signed [ACC_W-1:0] acc_q, sx_q, sy_q, acc_sum;
  logic signed [TAN_W-1:0] tx_q, ty_q;
  logic [TAN_W-1:0] ax_q, ay_q, m_w;
  logic [SQV_W-1:0] ssq_q;
  logic [LEN_W-1:0] len_q;
  logic signed [QUO_W-1:0] px_q, py_q, ox_q, oy_q, q_pos, q_neg;
  logic [ACC_W-1:0] sx_mag, sy_mag;
  logic signed [MUL_W-1:0] opa, opb;
  logic signed [PROD_W-1:0] prod_q;

  // shared arithmetic units
  logic div_start, div_done, sqrt_start, sqrt_done;
  logic [DVD_W-1:0] div_num;
  logic [DVS_W-1:0] div_den;
  logic [QUO_W-1:0] div_quot;
  logic [SQV_W-1:0] sqrt_val;
  logic [LEN_W-1:0] sqrt_root;

  cbst_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_quot)
  );

  cbst_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .start_i(sqrt_start), .val_i(sqrt_val),
    .done_o(sqrt_done), .root_o(sqrt_root)
  );

  function automatic logic [COORD_W-1:0] sat32(input logic signed [COORD_W+1:0] v);
    logic [COORD_W-1:0] r;
    if (v[COORD_W+1:COORD_W-1] == 3'b000 || v[COORD_W+1:COORD_W-1] == 3'b111) begin
      r = v[COORD_W-1:0];
    end else if (v[COORD_W+1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  // helper values
  always_comb begin
    u_w     = n_q - i_q;
    cb_w    = 20'(uu_q) * 20'(i_q) * 20'd3;
    cc_w    = 20'(tt_q) * 20'(u_w) * 20'd3;
    acc_sum = acc_q + $signed(prod_q[ACC_W-1:0]);
    m_w     = (ax_q > ay_q) ? ax_q : ay_q;
    sx_mag  = sx_q[ACC_W-1] ? ACC_W'(-sx_q) : sx_q;
    sy_mag  = sy_q[ACC_W-1] ? ACC_W'(-sy_q) : sy_q;
    q_pos   = $signed(div_quot);
    q_neg   = -$signed(div_quot);
    sqrt_val = ssq_q + prod_q[SQV_W-1:0];
  end

  // multiplier operand selection
  always_comb begin
    opa = '0;
    opb = '0;
    case (state_q)
      ST_MUL: begin
        case (k_q)
          4'd0:  begin opa = {15'd0, ca_q}; opb = {p0x_q[31], p0x_q}; end
          4'd1:  begin opa = {15'd0, cb_q}; opb = {c1x_q[31], c1x_q}; end
          4'd2:  begin opa = {15'd0, cc_q}; opb = {c2x_q[31], c2x_q}; end
          4'd3:  begin opa = {15'd0, cd_q}; opb = {p3x_q[31], p3x_q}; end
          4'd4:  begin opa = {15'd0, ca_q}; opb = {p0y_q[31], p0y_q}; end
          4'd5:  begin opa = {15'd0, cb_q}; opb = {c1y_q[31], c1y_q}; end
          4'd6:  begin opa = {15'd0, cc_q}; opb = {c2y_q[31], c2y_q}; end
          4'd7:  begin opa = {15'd0, cd_q}; opb = {p3y_q[31], p3y_q}; end
          4'd8:  begin opa = {21'd0, ce_q}; opb = d0x_q; end
          4'd9:  begin opa = {20'd0, cf_q}; opb = d1x_q; end
          4'd10: begin opa = {21'd0, cg_q}; opb = d2x_q; end
          4'd11: begin opa = {21'd0, ce_q}; opb = d0y_q; end
          4'd12: begin opa = {20'd0, cf_q}; opb = d1y_q; end
          4'd13: begin opa = {21'd0, cg_q}; opb = d2y_q; end
          default: begin opa = '0; opb = '0; end
        endcase
      end
      ST_SQ1: begin opa = {3'd0, ax_q[29:0]}; opb = {3'd0, ax_q[29:0]}; end
      ST_SQ2: begin opa = {3'd0, ay_q[29:0]}; opb = {3'd0, ay_q[29:0]}; end
      ST_OFS_MUL: begin
        opa = (sel_q == DIV_OX) ? {3'd0, ay_q[29:0]} : {3'd0, ax_q[29:0]};
        opb = {2'd0, w_q};
      end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // divider operands
  always_comb begin
    case (sel_q)
      DIV_PX: begin
        div_num = DVD_W'(sx_mag) + DVD_W'(n3_q >> 1);
        div_den = DVS_W'(n3_q);
      end
      DIV_PY: begin
        div_num = DVD_W'(sy_mag) + DVD_W'(n3_q >> 1);
        div_den = DVS_W'(n3_q);
      end
      default: begin
        div_num = DVD_W'(prod_q[60:0]) + DVD_W'(len_q);
        div_den = {len_q, 1'b0};
      end
    endcase
  end

  // step sequencer
  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    k_d         = k_q;
    i_d         = i_q;
    n_d         = n_q;
    vcnt_d      = vcnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_ready_o = 1'b0;
    div_start   = 1'b0;
    sqrt_start  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          if (cmd_i.is_clear) begin
            vcnt_d = '0;
          end else if (cmd_i.segs != '0) begin
            n_d     = cmd_i.segs;
            i_d     = '0;
            state_d = ST_COEF1;
          end
        end
      end
      ST_COEF1: state_d = ST_COEF2;
      ST_COEF2: begin
        k_d     = '0;
        state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        if (k_q == K_TY_END) begin
          sel_d   = DIV_PX;
          state_d = ST_DIV_GO;
        end else begin
          k_d     = k_q + 4'd1;
          state_d = ST_MUL;
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          case (sel_q)
            DIV_PX: begin
              sel_d   = DIV_PY;
              state_d = ST_DIV_GO;
            end
            DIV_PY: begin
              state_d = ((tx_q == '0) && (ty_q == '0)) ? ST_EMIT : ST_NORM;
            end
            DIV_OX: begin
              sel_d   = DIV_OY;
              state_d = ST_OFS_MUL;
            end
            default: state_d = ST_EMIT;
          endcase
        end
      end
      ST_NORM: begin
        if (m_w < NORM_HI && m_w >= NORM_LO) begin
          state_d = ST_SQ1;
        end
      end
      ST_SQ1: state_d = ST_SQ2;
      ST_SQ2: state_d = ST_SQ3;
      ST_SQ3: begin
        sqrt_start = 1'b1;
        state_d    = ST_SQRT;
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          sel_d   = DIV_OX;
          state_d = ST_OFS_MUL;
        end
      end
      ST_OFS_MUL: state_d = ST_DIV_GO;
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.left_x      = sat32(34'(px_q) - 34'(ox_q));
          out_d.left_y      = sat32(34'(py_q) - 34'(oy_q));
          out_d.right_x     = sat32(34'(px_q) + 34'(ox_q));
          out_d.right_y     = sat32(34'(py_q) + 34'(oy_q));
          out_d.left_num    = vcnt_q;
          out_d.right_num   = vcnt_q + VNUM_W'(1);
          out_d.color       = color_i;
          out_d.closes_quad = (i_q != '0);
          out_d.last        = (i_q == n_q);
          vcnt_d            = vcnt_q + VNUM_W'(2);
          if (i_q == n_q) begin
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_COEF1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= DIV_PX;
      k_q         <= '0;
      i_q         <= '0;
      n_q         <= '0;
      vcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      k_q         <= k_d;
      i_q         <= i_d;
      n_q         <= n_d;
      vcnt_q      <= vcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
    out_q  <= out_d;
    case (state_q)
      ST_IDLE: begin
        w_q   <= cmd_i.width;
        p0x_q <= cmd_i.p0x;  p0y_q <= cmd_i.p0y;
        p3x_q <= cmd_i.p3x;  p3y_q <= cmd_i.p3y;
        c1x_q <= cmd_i.c1x;  c1y_q <= cmd_i.c1y;
        c2x_q <= cmd_i.c2x;  c2y_q <= cmd_i.c2y;
        d0x_q <= DIFF_W'(cmd_i.c1x) - DIFF_W'(cmd_i.p0x);
        d0y_q <= DIFF_W'(cmd_i.c1y) - DIFF_W'(cmd_i.p0y);
        d1x_q <= DIFF_W'(cmd_i.c2x) - DIFF_W'(cmd_i.c1x);
        d1y_q <= DIFF_W'(cmd_i.c2y) - DIFF_W'(cmd_i.c1y);
        d2x_q <= DIFF_W'(cmd_i.p3x) - DIFF_W'(cmd_i.c2x);
        d2y_q <= DIFF_W'(cmd_i.p3y) - DIFF_W'(cmd_i.c2y);
      end
      ST_COEF1: begin
        uu_q <= SQR_W'(u_w) * SQR_W'(u_w);
        tt_q <= SQR_W'(i_q) * SQR_W'(i_q);
        ut_q <= SQR_W'(u_w) * SQR_W'(i_q);
        nn_q <= SQR_W'(n_q) * SQR_W'(n_q);
      end
      ST_COEF2: begin
        ca_q  <= COEF_W'(uu_q) * COEF_W'(u_w);
        cb_q  <= cb_w[COEF_W-1:0];
        cc_q  <= cc_w[COEF_W-1:0];
        cd_q  <= COEF_W'(tt_q) * COEF_W'(i_q);
        ce_q  <= uu_q;
        cf_q  <= {ut_q, 1'b0};
        cg_q  <= tt_q;
        n3_q  <= COEF_W'(nn_q) * COEF_W'(n_q);
        acc_q <= '0;
      end
      ST_ACC: begin
        if (k_q == K_PX_END || k_q == K_PY_END || k_q == K_TX_END || k_q == K_TY_END) begin
          acc_q <= '0;
        end else begin
          acc_q <= acc_sum;
        end
        if (k_q == K_PX_END) sx_q <= acc_sum;
        if (k_q == K_PY_END) sy_q <= acc_sum;
        if (k_q == K_TX_END) tx_q <= acc_sum[TAN_W-1:0];
        if (k_q == K_TY_END) ty_q <= acc_sum[TAN_W-1:0];
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          case (sel_q)
            DIV_PX: px_q <= sx_q[ACC_W-1] ? q_neg : q_pos;
            DIV_PY: begin
              py_q <= sy_q[ACC_W-1] ? q_neg : q_pos;
              ox_q <= '0;
              oy_q <= '0;
              ax_q <= tx_q[TAN_W-1] ? TAN_W'(-tx_q) : tx_q;
              ay_q <= ty_q[TAN_W-1] ? TAN_W'(-ty_q) : ty_q;
            end
            DIV_OX: ox_q <= (!ty_q[TAN_W-1] && ty_q != '0) ? q_neg : q_pos;
            default: oy_q <= tx_q[TAN_W-1] ? q_neg : q_pos;
          endcase
        end
      end
      ST_NORM: begin
        if (m_w >= NORM_HI) begin
          ax_q <= ax_q >> 1;
          ay_q <= ay_q >> 1;
        end else if (m_w < NORM_LO) begin
          ax_q <= ax_q << 1;
          ay_q <= ay_q << 1;
        end
      end
      ST_SQ2: ssq_q <= prod_q[SQV_W-1:0];
      ST_SQRT: begin
        if (sqrt_done) len_q <= sqrt_root;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/cbst_checker.sv =====
module cbst_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic [cbst_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tuser,
  input logic                             m_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready
);

  // a stalled result item stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item withdrawn while stalled");

  // and keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result item changed while stalled");

  // a curve has at least one segment, so its final pair always closes a quad
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("final pair does not close a quad");

  // right vertex number follows the left one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[159:144] == m_axis_tdata[143:128] + 16'd1)
    else $error("vertex numbers not consecutive");

endmodule

bind cubic_bezier_stroke_tessellator cbst_checker u_checker (.*);

// ===== test/tb.sv =====
module tb;
  import cbst_pkg::*;

  // one predicted vertex pair
  typedef struct {
    logic signed [COORD_W-1:0] left_x, left_y, right_x, right_y;
    logic [VNUM_W-1:0]         left_num, right_num;
    logic [COLOR_W-1:0]        color;
    logic                      closes_quad, last;
  } pair_t;

  // curve draw or clear request
  typedef struct {
    logic                      clear;
    logic signed [COORD_W-1:0] p0x, p0y, p3x, p3y, c1x, c1y, c2x, c2y;
    logic [WIDTH_W-1:0]        width;
    logic [SEG_W-1:0]          segs;
  } curve_t;

  class stroke_scoreboard;
    pair_t              pending[$];
    logic [COLOR_W-1:0] color = '1;
    logic [VNUM_W-1:0]  vnum  = '0;
    int                 errors = 0;
    int                 pairs_seen = 0;

    task report(string msg);
      $display("error at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function longint rnd_div(longint num, longint unsigned d);
      longint unsigned m, q;
      m = (num < 0) ? longint'(-num) : longint'(num);
      q = (m + d / 2) / d;
      return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
    endfunction

    // predict all pairs for an accepted item
    function void note_item(curve_t c);
      longint p0x, p0y, p3x, p3y, c1x, c1y, c2x, c2y, n3, u, t, px, py, tx, ty;
      longint ox, oy, sx, sy;
      longint unsigned n, w, ax, ay, m, len;
      pair_t pr;
      if (c.clear) begin
        vnum = '0;
        return;
      end
      n = c.segs;
      if (n > 63) n = 63;
      if (n == 0) return;
      w = c.width;
      p0x = c.p0x; p0y = c.p0y; p3x = c.p3x; p3y = c.p3y;
      c1x = c.c1x; c1y = c.c1y; c2x = c.c2x; c2y = c.c2y;
      n3 = n * n * n;
      for (longint i = 0; i <= n; i++) begin
        u = n - i;
        t = i;
        px = rnd_div(u*u*u*p0x + 3*u*u*t*c1x + 3*u*t*t*c2x + t*t*t*p3x, n3);
        py = rnd_div(u*u*u*p0y + 3*u*u*t*c1y + 3*u*t*t*c2y + t*t*t*p3y, n3);
        tx = u*u*(c1x-p0x) + 2*u*t*(c2x-c1x) + t*t*(p3x-c2x);
        ty = u*u*(c1y-p0y) + 2*u*t*(c2y-c1y) + t*t*(p3y-c2y);
        ax = (tx < 0) ? -tx : tx;
        ay = (ty < 0) ? -ty : ty;
        m = (ax > ay) ? ax : ay;
        if (m == 0) begin
          ox = 0;
          oy = 0;
        end else begin
          while (m >= (64'd1 << 30)) begin ax >>= 1; ay >>= 1; m >>= 1; end
          while (m < (64'd1 << 29)) begin ax <<= 1; ay <<= 1; m <<= 1; end
          len = int_sqrt(ax*ax + ay*ay);
          sx = (tx < 0) ? -longint'(ax) : longint'(ax);
          sy = (ty < 0) ? -longint'(ay) : longint'(ay);
          ox = rnd_div(-sy * longint'(w), 2 * len);
          oy = rnd_div(sx * longint'(w), 2 * len);
        end
        pr.left_x = clamp32(px - ox);
        pr.left_y = clamp32(py - oy);
        pr.right_x = clamp32(px + ox);
        pr.right_y = clamp32(py + oy);
        pr.left_num = vnum;
        pr.right_num = vnum + 16'd1;
        pr.color = color;
        pr.closes_quad = (i != 0);
        pr.last = (i == n);
        vnum += 16'd2;
        pending.push_back(pr);
      end
    endfunction

    task check_pair(pair_t got);
      pair_t e;
      pairs_seen++;
      if (pending.size() == 0) begin
        report("result item with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (got.left_x !== e.left_x)
        report($sformatf("left_x %h expected %h", got.left_x, e.left_x));
      if (got.left_y !== e.left_y)
        report($sformatf("left_y %h expected %h", got.left_y, e.left_y));
      if (got.right_x !== e.right_x)
        report($sformatf("right_x %h expected %h", got.right_x, e.right_x));
      if (got.right_y !== e.right_y)
        report($sformatf("right_y %h expected %h", got.right_y, e.right_y));
      if (got.left_num !== e.left_num)
        report($sformatf("left_number %h expected %h", got.left_num, e.left_num));
      if (got.right_num !== e.right_num)
        report($sformatf("right_number %h expected %h", got.right_num, e.right_num));
      if (got.color !== e.color)
        report($sformatf("pixel_color %h expected %h", got.color, e.color));
      if (got.closes_quad !== e.closes_quad)
        report($sformatf("closes_quad %b expected %b", got.closes_quad, e.closes_quad));
      if (got.last !== e.last)
        report($sformatf("last %b expected %b", got.last, e.last));
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [COLOR_W-1:0]     cfg_wdata_i = '0;

  stroke_scoreboard sb = new();
  int  tx_idle_pct = 0;
  int  rx_stall_pct = 0;
  bit  hold_req = 0;
  int  hold_left = 0;
  int  items_sent = 0;

  cubic_bezier_stroke_tessellator dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tuser, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tlast, .m_axis_tvalid, .m_axis_tready,
    .cfg_we_i, .cfg_wdata_i
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog
  initial begin
    #200000000;
    $display("Mismatches found");
    $finish;
  end

  // receiver side: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req <= 0;
      hold_left <= 3000;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    pair_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.left_x      = m_axis_tdata[31:0];
      got.left_y      = m_axis_tdata[63:32];
      got.right_x     = m_axis_tdata[95:64];
      got.right_y     = m_axis_tdata[127:96];
      got.left_num    = m_axis_tdata[143:128];
      got.right_num   = m_axis_tdata[159:144];
      got.color       = m_axis_tdata[191:160];
      got.closes_quad = m_axis_tuser;
      got.last        = m_axis_tlast;
      sb.check_pair(got);
    end
  end

  task send_curve(curve_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tuser <= c.clear;
    s_axis_tdata <= {3'b000, c.segs, c.width, c.c2y, c.c2x, c.c1y, c.c1x,
                     c.p3y, c.p3x, c.p0y, c.p0x};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(c);
    items_sent++;
    @(negedge clk_i);
  endtask

  task write_color(logic [COLOR_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.color = v;
  endtask

  // drain and let any result-free item finish before touching the register
  task wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  function logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(2097152) - 1048576;
      default: return $urandom_range(65536) - 32768;
    endcase
  endfunction

  function curve_t rand_curve();
    curve_t c;
    int mode, r;
    mode = $urandom_range(2);
    c.clear = ($urandom_range(99) < 5);
    {c.p0x, c.p0y, c.p3x, c.p3y} = {rand_coord(mode), rand_coord(mode),
                                     rand_coord(mode), rand_coord(mode)};
    {c.c1x, c.c1y, c.c2x, c.c2y} = {rand_coord(mode), rand_coord(mode),
                                     rand_coord(mode), rand_coord(mode)};
    // occasionally a collapsed curve, so the tangent vanishes
    if ($urandom_range(99) < 4) begin
      c.p3x = c.p0x; c.c1x = c.p0x; c.c2x = c.p0x;
      c.p3y = c.p0y; c.c1y = c.p0y; c.c2y = c.p0y;
    end
    c.width = ($urandom_range(3) == 0) ? WIDTH_W'($urandom)
                                       : WIDTH_W'($urandom_range(1 << 22));
    r = $urandom_range(99);
    if (r < 80) c.segs = SEG_W'($urandom_range(4));
    else if (r < 97) c.segs = SEG_W'($urandom_range(12, 5));
    else c.segs = SEG_W'($urandom_range(63, 32));
    return c;
  endfunction

  function curve_t make_curve(logic [31:0] a, logic [31:0] b, logic [30:0] w,
                              logic [5:0] n);
    curve_t c;
    c.clear = 1'b0;
    c.p0x = a; c.p0y = a; c.c1x = b; c.c1y = a;
    c.c2x = a; c.c2y = b; c.p3x = b; c.p3y = b;
    c.width = w;
    c.segs = n;
    return c;
  endfunction

  initial begin
    curve_t c;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset colour first, then edge cases
    send_curve(make_curve(32'h0001_0000, 32'h0005_0000, 31'h0002_0000, 6'd1));
    send_curve(make_curve(32'h0001_0000, 32'h0005_0000, 31'h0002_0000, 6'd0));
    send_curve(make_curve(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 6'd2));
    send_curve(make_curve(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 6'd3));
    send_curve(make_curve(32'h8000_0000, 32'h8000_0000, 31'h0001_0000, 6'd2));
    send_curve(make_curve(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 6'd1));
    send_curve(make_curve(32'hFFFF_0000, 32'h0003_0000, 31'h0, 6'd4));
    c = make_curve(32'hFFF0_0000, 32'h0010_0000, 31'h0004_0000, 6'd63);
    c.c1x = 32'h0;
    send_curve(c);
    c.clear = 1'b1;
    send_curve(c);
    c = make_curve(32'h0, 32'h0, 31'h0, 6'd0);
    c.clear = 1'b1;
    c.p0x = '1; c.p0y = '1; c.width = '1; c.segs = '1;
    send_curve(c);
    send_curve(make_curve(32'h1234_5678, 32'hEDCB_A987, 31'h2AAA_AAAA, 6'd5));
    wait_idle();
    write_color(32'h0000_0000);
    send_curve(make_curve(32'h0002_0000, 32'hFFFE_0000, 31'h0001_8000, 6'd2));
    wait_idle();
    write_color(32'hFFFF_FFFF);
    send_curve(make_curve(32'h0002_0000, 32'hFFFE_0000, 31'h0001_8000, 6'd1));

    // random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_color($urandom);
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 0;  rx_stall_pct = 83; hold_req = 1; end
        2: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
        default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
      endcase
      for (int k = 0; k < 80; k++) send_curve(rand_curve());
    end

    wait_idle();
    $display("sent %0d items (draws, clears, degenerate and saturating curves)",
             items_sent);
    $display("checked %0d vertex pairs over four idling phases", sb.pairs_seen);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/cbst_pkg.sv
rtl/cbst_front.sv
rtl/cbst_div.sv
rtl/cbst_sqrt.sv
rtl/cbst_back.sv
rtl/cubic_bezier_stroke_tessellator.sv
rtl/cbst_checker.sv
test/tb.sv
